FILE: rtl/aff2d_pkg.sv
// Shared types, widths and constants for the 2D affine transform core.
// Depends on nothing; every other file in rtl/ imports it.
package aff2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int FIELD_W   = 32;
  localparam int SAT_BITS  = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;

  // product, product after the fraction shift, and sum of two of them plus a word
  localparam int PROD_W = 2 * FIELD_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SH_W + 2;

  localparam longint SAT_MAX_L = (longint'(1) <<< (SAT_BITS - 1)) - longint'(1);
  localparam longint ONE_RAW_L = longint'(1) <<< FRAC_BITS;
  localparam longint ONE_L     = (ONE_RAW_L > SAT_MAX_L) ? SAT_MAX_L : ONE_RAW_L;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(SAT_MAX_L);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);
  localparam logic signed [FIELD_W-1:0] ONE_WORD = FIELD_W'(ONE_L);

  typedef enum logic [1:0] {
    MODE_COMPOSE = 2'd0,
    MODE_POINT   = 2'd1,
    MODE_SCALE   = 2'd2,
    MODE_IDENT   = 2'd3
  } aff2d_mode_e;

  typedef logic signed [FIELD_W-1:0] aff2d_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    aff2d_word_t m11;
    aff2d_word_t m12;
    aff2d_word_t m13;
    aff2d_word_t m21;
    aff2d_word_t m22;
    aff2d_word_t m23;
    aff2d_word_t x_in;
    aff2d_word_t y_in;
  } aff2d_in_t;

  typedef struct packed {
    aff2d_word_t rx;
    aff2d_word_t ry;
    aff2d_word_t cur11;
    aff2d_word_t cur12;
    aff2d_word_t cur13;
    aff2d_word_t cur21;
    aff2d_word_t cur22;
    aff2d_word_t cur23;
    logic        saturated;
  } aff2d_out_t;

  typedef struct packed {
    aff2d_word_t a11;
    aff2d_word_t a12;
    aff2d_word_t a13;
    aff2d_word_t a21;
    aff2d_word_t a22;
    aff2d_word_t a23;
  } aff2d_mat_t;

  typedef struct packed {
    aff2d_word_t val;
    logic        clip;
  } aff2d_sat_t;

  localparam aff2d_mat_t IDENTITY = '{
    a11: ONE_WORD, a12: '0, a13: '0,
    a21: '0, a22: ONE_WORD, a23: '0
  };

  function automatic aff2d_sat_t sat_word(logic signed [ACC_W-1:0] v);
    aff2d_sat_t r;
    if (v > SAT_MAX) begin
      r.val  = SAT_MAX[FIELD_W-1:0];
      r.clip = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val  = SAT_MIN[FIELD_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[FIELD_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/aff2d_dot.sv
// Two-term fixed-point dot product plus offset, floored and saturated.
// Depends on aff2d_pkg.
module aff2d_dot (
  input  aff2d_pkg::aff2d_word_t a0_i,
  input  aff2d_pkg::aff2d_word_t b0_i,
  input  aff2d_pkg::aff2d_word_t a1_i,
  input  aff2d_pkg::aff2d_word_t b1_i,
  input  aff2d_pkg::aff2d_word_t c_i,
  output aff2d_pkg::aff2d_sat_t  res_o
);
  import aff2d_pkg::*;

  logic signed [PROD_W-1:0] p0, p1;
  logic signed [SH_W-1:0]   s0, s1;
  logic signed [ACC_W-1:0]  t0, t1, tc, sum;

  assign p0 = a0_i * b0_i;
  assign p1 = a1_i * b1_i;

  // arithmetic shift floors toward minus infinity
  assign s0 = SH_W'(p0 >>> FRAC_BITS);
  assign s1 = SH_W'(p1 >>> FRAC_BITS);

  assign t0 = $signed({{2{s0[SH_W-1]}}, s0});
  assign t1 = $signed({{2{s1[SH_W-1]}}, s1});
  assign tc = $signed({{(ACC_W-FIELD_W){c_i[FIELD_W-1]}}, c_i});

  assign sum   = t0 + t1 + tc;
  assign res_o = sat_word(sum);

endmodule

FILE: rtl/aff2d_step.sv
// One command's arithmetic: six shared dot units, operand selection per mode,
// next matrix and result word. Depends on aff2d_pkg and aff2d_dot.
module aff2d_step (
  input  aff2d_pkg::aff2d_in_t  item_i,
  input  aff2d_pkg::aff2d_mat_t mat_i,
  output aff2d_pkg::aff2d_mat_t mat_o,
  output aff2d_pkg::aff2d_out_t res_o
);
  import aff2d_pkg::*;

  logic        is_point, is_scale;
  aff2d_word_t b0_u0, b1_u0, b0_tr, b1_tr;
  aff2d_sat_t  u0, u1, u2, u3, u4, u5;

  assign is_point = (item_i.mode == MODE_POINT);
  assign is_scale = (item_i.mode == MODE_SCALE);

  // unit 0 doubles as the length scaler, units 2 and 5 as the point mapper
  assign b0_u0 = is_scale ? item_i.x_in : item_i.m11;
  assign b1_u0 = is_scale ? '0 : item_i.m21;
  assign b0_tr = is_point ? item_i.x_in : item_i.m13;
  assign b1_tr = is_point ? item_i.y_in : item_i.m23;

  aff2d_dot u_d0 (.a0_i(mat_i.a11), .b0_i(b0_u0), .a1_i(mat_i.a12), .b1_i(b1_u0),
                  .c_i('0), .res_o(u0));
  aff2d_dot u_d1 (.a0_i(mat_i.a11), .b0_i(item_i.m12), .a1_i(mat_i.a12),
                  .b1_i(item_i.m22), .c_i('0), .res_o(u1));
  aff2d_dot u_d2 (.a0_i(mat_i.a11), .b0_i(b0_tr), .a1_i(mat_i.a12), .b1_i(b1_tr),
                  .c_i(mat_i.a13), .res_o(u2));
  aff2d_dot u_d3 (.a0_i(mat_i.a21), .b0_i(item_i.m11), .a1_i(mat_i.a22),
                  .b1_i(item_i.m21), .c_i('0), .res_o(u3));
  aff2d_dot u_d4 (.a0_i(mat_i.a21), .b0_i(item_i.m12), .a1_i(mat_i.a22),
                  .b1_i(item_i.m22), .c_i('0), .res_o(u4));
  aff2d_dot u_d5 (.a0_i(mat_i.a21), .b0_i(b0_tr), .a1_i(mat_i.a22), .b1_i(b1_tr),
                  .c_i(mat_i.a23), .res_o(u5));

  aff2d_mat_t mat_n;
  logic       sat;
  aff2d_word_t rx, ry;

  always_comb begin
    mat_n = mat_i;
    rx    = '0;
    ry    = '0;
    sat   = 1'b0;
    case (item_i.mode)
      MODE_COMPOSE: begin
        mat_n = '{a11: u0.val, a12: u1.val, a13: u2.val,
                  a21: u3.val, a22: u4.val, a23: u5.val};
        sat   = u0.clip | u1.clip | u2.clip | u3.clip | u4.clip | u5.clip;
      end
      MODE_POINT: begin
        rx  = u2.val;
        ry  = u5.val;
        sat = u2.clip | u5.clip;
      end
      MODE_SCALE: begin
        rx  = u0.val;
        sat = u0.clip;
      end
      MODE_IDENT: begin
        mat_n = IDENTITY;
      end
      default: begin
        mat_n = mat_i;
      end
    endcase
  end

  assign mat_o = mat_n;
  assign res_o = '{rx: rx, ry: ry,
                   cur11: mat_n.a11, cur12: mat_n.a12, cur13: mat_n.a13,
                   cur21: mat_n.a21, cur22: mat_n.a22, cur23: mat_n.a23,
                   saturated: sat};

endmodule

FILE: rtl/affine_transform_2d_core.sv
// An accepted word is held in the input register until its result is registered.
// Throughput: one word per cycle unless the result register stalls; the matrix
// register feeds back through the six multiply-add units of the step logic.
// Reset: asynchronous, active low; the matrix returns to identity and both
// the input and result registers are emptied.
// Depends on aff2d_pkg and aff2d_step.
module affine_transform_2d_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aff2d_pkg::aff2d_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aff2d_pkg::aff2d_out_t out_data_o
);
  import aff2d_pkg::*;

  aff2d_in_t  in_q;
  logic       in_valid_q, in_valid_d;
  aff2d_mat_t mat_q, mat_d;
  aff2d_out_t out_q;
  logic       out_valid_q, out_valid_d;
  aff2d_out_t res;
  logic       adv;

  aff2d_step u_step (
    .item_i(in_q),
    .mat_i (mat_q),
    .mat_o (mat_d),
    .res_o (res)
  );

  // the held word moves on when the result register is empty or draining
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mat_q       <= IDENTITY;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        mat_q <= mat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_mat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(mat_q))
    else $error("matrix changed without a word advancing");

  a_res_mat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && out_q.cur11 == mat_q.a11 && out_q.cur23 == mat_q.a23)
    else $error("result matrix differs from stored matrix");

  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.mode == MODE_IDENT |=> !out_q.saturated && mat_q == IDENTITY)
    else $error("identity load wrong");

  a_ry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.mode != MODE_POINT |=> out_q.ry == '0)
    else $error("ry nonzero outside point mode");
`endif

endmodule
